// ----- src/xtksp_pkg.sv -----
// shared types and constants of the xt keyboard and system port block
// no dependencies; used by xtksp_core and the top level

package xtksp_pkg;

    localparam int RING_DEPTH_DEF = 16;

    localparam logic [1:0] CMD_KEY   = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [2:0] PORT_DATA  = 3'd0;
    localparam logic [2:0] PORT_PB    = 3'd1;
    localparam logic [2:0] PORT_SYS   = 3'd2;
    localparam logic [2:0] PORT_SPARE = 3'd3;
    localparam logic [2:0] PORT_STAT1 = 3'd4;
    localparam logic [2:0] PORT_STAT2 = 3'd5;

    localparam int PB_GATE_BIT   = 0;
    localparam int PB_SPK_BIT    = 1;
    localparam int PB_NIB_BIT    = 2;
    localparam int PB_RESET_BIT  = 6;
    localparam int PB_CLEAR_BIT  = 7;

    localparam logic [7:0] SCAN_SELFTEST = 8'hAA;
    localparam logic [7:0] STAT_SET      = 8'h0D;
    localparam logic [7:0] STAT_MASK     = 8'h7F;
    localparam logic [7:0] READ_IDLE     = 8'hFF;

    typedef struct packed {
        logic [1:0] command;
        logic [2:0] port_offset;
        logic [7:0] data_byte;
        logic       speaker_level;
        logic       nmi_pending;
    } req_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_raise;
        logic       speaker_gate;
        logic       speaker_on;
        logic       bad_port;
    } rsp_item_t;

endpackage

// ----- src/xtksp_if.sv -----
// valid/ready channel interfaces for request and result transactions
// no dependencies

interface xtksp_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [2:0] port_offset;
    logic [7:0] data_byte;
    logic       speaker_level;
    logic       nmi_pending;

    modport source (output valid, command, port_offset, data_byte, speaker_level,
                    nmi_pending, input ready);
    modport sink (input valid, command, port_offset, data_byte, speaker_level,
                  nmi_pending, output ready);
endinterface

interface xtksp_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq_raise;
    logic       speaker_gate;
    logic       speaker_on;
    logic       bad_port;

    modport source (output valid, read_data, irq_raise, speaker_gate, speaker_on,
                    bad_port, input ready);
    modport sink (input valid, read_data, irq_raise, speaker_gate, speaker_on,
                  bad_port, output ready);
endinterface

// ----- src/xtksp_ram.sv -----
// generic single write port ram with registered read
// no dependencies

module xtksp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/xtksp_core.sv -----
// port decode, scan-code ring control and keyboard state registers
// depends on xtksp_pkg; drives the ring ram in the top level

module xtksp_core
    import xtksp_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  req_item_t                     item,
    input  logic [7:0]                    ring_rdata,
    output logic                          ring_we,
    output logic [$clog2(RING_DEPTH)-1:0] ring_waddr,
    output logic [7:0]                    ring_wdata,
    output logic [$clog2(RING_DEPTH)-1:0] ring_raddr,
    output rsp_item_t                     result
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [7:0]       pend_reg, pend_next;
    logic [7:0]       latch_reg, latch_next;
    logic             irqw_reg, irqw_next;
    logic [7:0]       pb_reg, pb_next;
    logic [7:0]       stat1_reg, stat1_next;
    logic [7:0]       stat2_reg, stat2_next;
    logic             byp_valid_reg;
    logic [7:0]       byp_data_reg;

    logic             push;
    logic [7:0]       push_data;
    logic             pop;
    logic [7:0]       rd;
    logic             irq;
    logic             bad;
    logic [7:0]       ring_q;
    logic [3:0]       nib;
    logic             ring_empty;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    // head entry of the ring, with a write to the same slot forwarded
    assign ring_q     = byp_valid_reg ? byp_data_reg : ring_rdata;
    assign ring_empty = (head_reg == tail_reg);
    assign nib        = pb_reg[PB_NIB_BIT] ? stat2_reg[3:0] : stat2_reg[7:4];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        pend_next  = pend_reg;
        latch_next = latch_reg;
        irqw_next  = irqw_reg;
        pb_next    = pb_reg;
        stat1_next = stat1_reg;
        stat2_next = stat2_reg;
        push       = 1'b0;
        push_data  = item.data_byte;
        pop        = 1'b0;
        rd         = READ_IDLE;
        irq        = 1'b0;
        bad        = 1'b0;
        if (en)
        begin
            case (item.command)
                CMD_KEY:
                begin
                    push = 1'b1;
                end
                CMD_TICK:
                begin
                    if (irqw_reg)
                    begin
                        irqw_next  = 1'b0;
                        latch_next = pend_reg;
                        irq        = 1'b1;
                    end
                    if (!ring_empty && latch_next == 8'h00)
                    begin
                        pop = 1'b1;
                    end
                end
                CMD_WRITE:
                begin
                    case (item.port_offset)
                        PORT_PB:
                        begin
                            if (!pb_reg[PB_RESET_BIT] && item.data_byte[PB_RESET_BIT])
                            begin
                                push      = 1'b1;
                                push_data = SCAN_SELFTEST;
                            end
                            pb_next = item.data_byte;
                            if (item.data_byte[PB_CLEAR_BIT])
                            begin
                                latch_next = 8'h00;
                            end
                        end
                        PORT_SPARE:
                        begin
                        end
                        PORT_STAT1:
                        begin
                            stat1_next = item.data_byte;
                        end
                        PORT_STAT2:
                        begin
                            stat2_next = item.data_byte;
                        end
                        default:
                        begin
                            bad = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                    case (item.port_offset)
                        PORT_DATA:
                        begin
                            if (pb_reg[PB_CLEAR_BIT])
                            begin
                                rd = (stat1_reg | STAT_SET) & STAT_MASK;
                            end
                            else
                            begin
                                rd = latch_reg;
                                if (ring_empty)
                                begin
                                    irqw_next = 1'b0;
                                end
                                else
                                begin
                                    pop = 1'b1;
                                end
                            end
                        end
                        PORT_PB:
                        begin
                            rd = pb_reg;
                        end
                        PORT_SYS:
                        begin
                            rd = {1'b0, item.nmi_pending, item.speaker_level, 1'b0, nib};
                        end
                        default:
                        begin
                            bad = 1'b1;
                        end
                    endcase
                end
            endcase
        end
        if (pop)
        begin
            pend_next = ring_q;
            head_next = ptr_inc(head_reg);
            irqw_next = 1'b1;
        end
        if (push)
        begin
            tail_next = ptr_inc(tail_reg);
        end
    end

    assign ring_we    = push;
    assign ring_waddr = tail_reg;
    assign ring_wdata = push_data;
    assign ring_raddr = head_next;

    assign result.read_data    = rd;
    assign result.irq_raise    = irq;
    assign result.speaker_gate = pb_next[PB_GATE_BIT];
    assign result.speaker_on   = pb_next[PB_SPK_BIT];
    assign result.bad_port     = bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            pend_reg      <= 8'h00;
            latch_reg     <= 8'h00;
            irqw_reg      <= 1'b0;
            pb_reg        <= 8'h00;
            stat1_reg     <= 8'h00;
            stat2_reg     <= 8'h00;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            pend_reg      <= pend_next;
            latch_reg     <= latch_next;
            irqw_reg      <= irqw_next;
            pb_reg        <= pb_next;
            stat1_reg     <= stat1_next;
            stat2_reg     <= stat2_next;
            byp_valid_reg <= push && (tail_reg == head_next);
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= push_data;
    end

endmodule

// ----- src/xt_keyboard_system_port.sv -----
// top level of the xt keyboard and system port block
// depends on xtksp_pkg, xtksp_if, xtksp_ram and xtksp_core
//
// usage:
//   req carries one transaction per item: a key code, a poll tick, a bus
//   write or a bus read of ports 0x60 to 0x65 (port_offset 0 to 5)
//   rsp returns exactly one transaction per request, in order: read data,
//   irq raise on a tick, the speaker gate and enable bits of the control
//   byte, and a flag for undecoded ports
//   a taken request is held in the input register, decoded by the core,
//   and its result is registered in the result register that drives rsp
//   throughput: one transaction per cycle while rsp does not stall, set by
//   the single pass through the decode logic and the one-read one-write ring ram
//   reset clears the ring pointers, the control and status bytes, the
//   latch, the pending key and the irq request; ring contents are not
//   cleared and need no clearing pass
//   when rsp stalls, the result register holds, one more request is held
//   in the input register, and req.ready then drops until rsp moves

module xt_keyboard_system_port
    import xtksp_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    xtksp_req_if.sink   req,
    xtksp_rsp_if.source rsp
);

    localparam int PTR_W = $clog2(RING_DEPTH);

    logic      s1_valid_reg, s1_valid_next;
    req_item_t s1_item_reg;
    logic      out_valid_reg, out_valid_next;
    rsp_item_t out_item_reg;

    logic      advance;
    logic      take;
    logic      en;
    req_item_t req_item;
    rsp_item_t result;

    logic             ring_we;
    logic [PTR_W-1:0] ring_waddr;
    logic [7:0]       ring_wdata;
    logic [PTR_W-1:0] ring_raddr;
    logic [7:0]       ring_rdata;

    assign req_item.command       = req.command;
    assign req_item.port_offset   = req.port_offset;
    assign req_item.data_byte     = req.data_byte;
    assign req_item.speaker_level = req.speaker_level;
    assign req_item.nmi_pending   = req.nmi_pending;

    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || advance;
    assign take      = req.valid && req.ready;
    assign en        = s1_valid_reg && advance;

    assign s1_valid_next  = req.ready ? req.valid : s1_valid_reg;
    assign out_valid_next = advance ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_item_reg <= req_item;
        end
        if (en)
        begin
            out_item_reg <= result;
        end
    end

    xtksp_core #(
        .RING_DEPTH (RING_DEPTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .item       (s1_item_reg),
        .ring_rdata (ring_rdata),
        .ring_we    (ring_we),
        .ring_waddr (ring_waddr),
        .ring_wdata (ring_wdata),
        .ring_raddr (ring_raddr),
        .result     (result)
    );

    xtksp_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    assign rsp.valid        = out_valid_reg;
    assign rsp.read_data    = out_item_reg.read_data;
    assign rsp.irq_raise    = out_item_reg.irq_raise;
    assign rsp.speaker_gate = out_item_reg.speaker_gate;
    assign rsp.speaker_on   = out_item_reg.speaker_on;
    assign rsp.bad_port     = out_item_reg.bad_port;

endmodule

// ----- src/xtksp_checker.sv -----
// port-level checks of the xt keyboard and system port block
// depends on nothing but the top level ports; bound to the top level below

module xtksp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] rsp_read_data,
    input logic       rsp_irq_raise,
    input logic       rsp_bad_port
);

    // a result transaction stays offered until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped before it was taken");

    // a taken request shows its result once the result side is free
    a_req_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
        else $error("accepted request produced no result");

    // undecoded ports only come from bus cycles, never from a tick
    a_bad_no_irq: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_bad_port |-> !rsp_irq_raise)
        else $error("irq raised on an undecoded bus access");

    a_bad_idle_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_bad_port |-> rsp_read_data == 8'hFF)
        else $error("undecoded port returned data");

endmodule

bind xt_keyboard_system_port xtksp_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_read_data (rsp.read_data),
    .rsp_irq_raise (rsp.irq_raise),
    .rsp_bad_port  (rsp.bad_port)
);
